[hdl/cobs_frame_decoder_core_defines.svh]
// Assertion macros used by the checker of the COBS frame decoder.
`ifndef COBS_FRAME_DECODER_CORE_DEFINES_SVH
`define COBS_FRAME_DECODER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define COBSFD_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cobsfd assertion failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define COBSFD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cobsfd assertion failed");

`endif

[hdl/cobsfd_pkg.sv]
// Package with the constants and status codes of the COBS frame decoder.
package cobsfd_pkg;

   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned LEN_W    = 13;
   localparam int unsigned STATUS_W = 2;

   localparam logic [BYTE_W-1:0] CODE_MAX      = 8'hFF;
   localparam logic [LEN_W-1:0]  COUNT_MAX     = 13'h1FFF;
   localparam logic [LEN_W-1:0]  MAX_LEN_RESET = 13'd256;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_GOOD      = 2'd0,
      STATUS_SYNC_LOST = 2'd1,
      STATUS_EMPTY     = 2'd2
   } status_type;

endpackage

[hdl/cobs_frame_decoder_core.sv]
// COBS frame decoder: one coded byte in per word, at most one decoded word out.
//
// The req_ channel takes one coded byte per word; a zero byte is the frame
// delimiter. The rsp_ channel returns decoded data bytes, and for every
// delimiter one end-of-frame word with rsp_frame_end high and a status of
// ok, synchro lost (delimiter inside a group, or the frame too long) or
// empty frame. Code bytes that owe no decoded zero produce no word.
// The csr_ channel writes the length limit, which counts two bytes of
// overhead; write it only while no frame traffic is in flight.
// The word caused by an accepted byte is shown on rsp_ in the cycle after it is
// accepted. Throughput is one byte per cycle while the receiver keeps up, set by
// the single decode stage in front of the result register; req_ready stays
// high while the result register is empty or is being drained this cycle.
// When the receiver stalls, the pending word holds and req_ready drops until
// it is taken. Synchronous reset clears the frame state, empties the result
// register and restores the length limit to 256.
module cobs_frame_decoder_core
   import cobsfd_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   // coded byte input
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [BYTE_W-1:0]   req_in_byte,
   // decoded word output
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [BYTE_W-1:0]   rsp_out_byte,
   output logic                rsp_frame_end,
   output logic [STATUS_W-1:0] rsp_status,
   // length limit register
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [LEN_W-1:0]    csr_max_decoded_length
);

   // Frame state.
   logic [BYTE_W-1:0] group_left_ff, group_left_in;
   logic              prev_max_ff, prev_max_in;
   logic              started_ff, started_in;
   logic [LEN_W-1:0]  count_ff, count_in;
   logic [LEN_W-1:0]  max_len_ff, max_len_in;

   // Result register.
   logic              out_valid_ff, out_valid_in;
   logic [BYTE_W-1:0] out_byte_ff, out_byte_in;
   logic              out_end_ff, out_end_in;
   status_type        out_status_ff, out_status_in;

   logic              req_fire;
   logic              has_result;
   logic [LEN_W-1:0]  count_inc;
   logic              too_long;

   // The register is always free to take a write.
   assign csr_ready  = 1'b1;
   assign max_len_in = csr_valid ? csr_max_decoded_length : max_len_ff;

   // A new byte may enter whenever the pending word leaves in the same cycle.
   assign req_ready = !out_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;

   // The decoded byte count saturates rather than wrapping.
   assign count_inc = (count_ff == COUNT_MAX) ? count_ff : count_ff + 1'b1;
   assign too_long  = ({1'b0, count_ff} + 14'd2) > {1'b0, max_len_ff};

   // Decode step: next frame state and the word this byte produces.
   always_comb begin
      group_left_in = group_left_ff;
      prev_max_in   = prev_max_ff;
      started_in    = started_ff;
      count_in      = count_ff;
      has_result    = 1'b0;
      out_byte_in   = '0;
      out_end_in    = 1'b0;
      out_status_in = STATUS_GOOD;
      if (req_in_byte == '0) begin
         // The delimiter closes the frame and returns every frame-state field to reset.
         has_result = 1'b1;
         out_end_in = 1'b1;
         if (!started_ff) begin
            out_status_in = STATUS_EMPTY;
         end else if (group_left_ff != '0 || too_long) begin
            out_status_in = STATUS_SYNC_LOST;
         end
         group_left_in = '0;
         prev_max_in   = 1'b1;
         started_in    = 1'b0;
         count_in      = '0;
      end else if (group_left_ff != '0) begin
         // Data byte inside a group passes through unchanged.
         has_result    = 1'b1;
         out_byte_in   = req_in_byte;
         group_left_in = group_left_ff - 1'b1;
         count_in      = count_inc;
      end else begin
         // Code byte: opens a new group and may first emit the zero that
         // ended the previous group. A maximal code owes no zero.
         has_result    = started_ff && !prev_max_ff;
         group_left_in = req_in_byte - 1'b1;
         prev_max_in   = (req_in_byte == CODE_MAX);
         started_in    = 1'b1;
         if (has_result) begin
            count_in = count_inc;
         end
      end
   end

   // Result valid: loaded by an accepted byte, cleared when the word is taken.
   always_comb begin
      out_valid_in = out_valid_ff;
      if (req_fire) begin
         out_valid_in = has_result;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         group_left_ff <= '0;
         prev_max_ff   <= 1'b1;
         started_ff    <= 1'b0;
         count_ff      <= '0;
         max_len_ff    <= MAX_LEN_RESET;
         out_valid_ff  <= 1'b0;
      end else begin
         max_len_ff   <= max_len_in;
         out_valid_ff <= out_valid_in;
         if (req_fire) begin
            group_left_ff <= group_left_in;
            prev_max_ff   <= prev_max_in;
            started_ff    <= started_in;
            count_ff      <= count_in;
         end
      end
   end

   // Payload of the result register needs no reset.
   always_ff @(posedge clock) begin
      if (req_fire && has_result) begin
         out_byte_ff   <= out_byte_in;
         out_end_ff    <= out_end_in;
         out_status_ff <= out_status_in;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_out_byte  = out_byte_ff;
   assign rsp_frame_end = out_end_ff;
   assign rsp_status    = out_status_ff;

endmodule

[hdl/cobsfd_checker.sv]
// Port-level checker for the COBS frame decoder, bound to the top level.
`include "cobs_frame_decoder_core_defines.svh"

module cobsfd_checker
   import cobsfd_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic [BYTE_W-1:0]   req_in_byte,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [BYTE_W-1:0]   rsp_out_byte,
   input logic                rsp_frame_end,
   input logic [STATUS_W-1:0] rsp_status
);

   logic rsp_stall;
   logic delim_fire;
   logic status_known;

   assign rsp_stall    = rsp_valid && !rsp_ready;
   assign delim_fire   = req_valid && req_ready && req_in_byte == '0;
   assign status_known = rsp_status == STATUS_GOOD || rsp_status == STATUS_SYNC_LOST
                         || rsp_status == STATUS_EMPTY;

   // A stalled word holds.
   `COBSFD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid && $stable({rsp_out_byte, rsp_frame_end, rsp_status}))

   // Every accepted delimiter yields an end-of-frame word in the next cycle.
   `COBSFD_ASSERT_NEXT(a_delim_ends, clock, reset, delim_fire, rsp_valid && rsp_frame_end)

   // Data words carry status ok.
   `COBSFD_ASSERT_IMP(a_data_ok, clock, reset, rsp_valid && !rsp_frame_end, rsp_status == STATUS_GOOD)

   // End words carry a zero byte and a defined status.
   `COBSFD_ASSERT_IMP(a_end_form, clock, reset, rsp_valid && rsp_frame_end, rsp_out_byte == '0 && status_known)

endmodule

bind cobs_frame_decoder_core cobsfd_checker u_cobsfd_checker (.*);
